// ===== design/atl_pkg.sv =====
// Package for the tilt/low-pass block: widths, constants, CORDIC angle table
// and the controller-to-datapath command word. No dependencies.
package atl_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ROOT_STEPS   = 24;
  localparam int STEP_W       = 5;

  localparam logic [16:0] WEIGHT_RESET = 17'd3932;
  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic signed [17:0] ANGLE_LIMIT = 18'sd23040;

  typedef enum logic [1:0] {
    MUL_SQA,
    MUL_SQB,
    MUL_FLO,
    MUL_FHI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADDHI
  } acc_op_e;

  typedef struct packed {
    logic              load_in;
    logic              phase;      // 0: roll, 1: pitch
    mul_sel_e          mul_sel;
    acc_op_e           acc_op;
    logic              root_init;
    logic              root_step;
    logic              cord_init;
    logic              cord_step;
    logic              ang_load;
    logic              diff_load;
    logic              filt_upd;
    logic              out_load;
    logic [STEP_W-1:0] idx;
  } atl_cmd_t;

  // round(atan(2^-i) in degrees * 65536)
  function automatic logic signed [24:0] atan_tab(input logic [STEP_W-1:0] i);
    logic signed [24:0] t;
    case (i)
      5'd0:    t = 25'sd2949120;
      5'd1:    t = 25'sd1740967;
      5'd2:    t = 25'sd919879;
      5'd3:    t = 25'sd466945;
      5'd4:    t = 25'sd234379;
      5'd5:    t = 25'sd117304;
      5'd6:    t = 25'sd58666;
      5'd7:    t = 25'sd29335;
      5'd8:    t = 25'sd14668;
      5'd9:    t = 25'sd7334;
      5'd10:   t = 25'sd3667;
      5'd11:   t = 25'sd1833;
      5'd12:   t = 25'sd917;
      5'd13:   t = 25'sd458;
      5'd14:   t = 25'sd229;
      5'd15:   t = 25'sd115;
      5'd16:   t = 25'sd57;
      5'd17:   t = 25'sd29;
      5'd18:   t = 25'sd14;
      5'd19:   t = 25'sd7;
      5'd20:   t = 25'sd4;
      5'd21:   t = 25'sd2;
      5'd22:   t = 25'sd1;
      default: t = 25'sd0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/atl_ctrl.sv =====
// Sequencer for the tilt/low-pass block: walks roll then pitch through the
// shared datapath. Depends on atl_pkg.
module atl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output atl_pkg::atl_cmd_t cmd_o
);
  import atl_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQA   = 4'd1;
  localparam logic [3:0] S_SQB   = 4'd2;
  localparam logic [3:0] S_SQC   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_ANG   = 4'd7;
  localparam logic [3:0] S_DIFF  = 4'd8;
  localparam logic [3:0] S_FM1   = 4'd9;
  localparam logic [3:0] S_FM2   = 4'd10;
  localparam logic [3:0] S_FM3   = 4'd11;
  localparam logic [3:0] S_UPD   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              phase_q, phase_d;
  logic              ovld_q, ovld_d;
  atl_cmd_t          cmd;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    cmd           = '0;
    cmd.mul_sel   = MUL_SQA;
    cmd.acc_op    = ACC_HOLD;
    cmd.phase     = phase_q;
    cmd.idx       = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          phase_d     = 1'b0;
          state_d     = S_SQA;
        end
      end
      S_SQA: begin
        cmd.mul_sel = MUL_SQA;
        state_d     = S_SQB;
      end
      S_SQB: begin
        cmd.mul_sel = MUL_SQB;
        cmd.acc_op  = ACC_LOAD;
        state_d     = S_SQC;
      end
      S_SQC: begin
        cmd.root_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_q == STEP_W'(ROOT_STEPS - 1)) begin
          state_d = S_CINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = S_ANG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ANG: begin
        cmd.ang_load = 1'b1;
        state_d      = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_load = 1'b1;
        state_d       = S_FM1;
      end
      S_FM1: begin
        cmd.mul_sel = MUL_FLO;
        state_d     = S_FM2;
      end
      S_FM2: begin
        cmd.mul_sel = MUL_FHI;
        cmd.acc_op  = ACC_LOAD;
        state_d     = S_FM3;
      end
      S_FM3: begin
        cmd.acc_op = ACC_ADDHI;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd.filt_upd = 1'b1;
        if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_SQA;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovld_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovld_d = ovld_q;
    if (cmd.out_load) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;
  assign cmd_o       = cmd;

endmodule

// ===== design/atl_dpath.sv =====
// Datapath for the tilt/low-pass block: shared multiplier, bit-serial square
// root, CORDIC vectoring unit and the two filter states. Depends on atl_pkg.
module atl_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atl_pkg::atl_cmd_t cmd_i,
  input  logic [16:0]       weight_i,
  input  logic [47:0]       in_data_i,
  output logic [31:0]       out_data_o
);
  import atl_pkg::*;

  logic signed [15:0] rx_q, ry_q, rz_q;
  logic signed [16:0] num;
  logic signed [15:0] sa;
  logic signed [17:0] w_eff, mul_a, mul_b;
  logic signed [35:0] prod_q;
  logic signed [51:0] acc_q;
  logic [47:0]        n_q;
  logic [27:0]        rem_q, rem_sh, trial;
  logic [23:0]        root_q;
  logic signed [27:0] u_q, v_q;
  logic signed [24:0] ang_acc_q;
  logic               num_zero_q, num_neg_q, root_zero_q;
  logic signed [17:0] ang_rnd;
  logic signed [15:0] angle, angle_q;
  logic signed [33:0] diff_q;
  logic signed [31:0] roll_f_q, pitch_f_q, old_f, new_f;
  logic signed [51:0] step_full;
  logic [15:0]        roll_out_q, pitch_out_q;
  logic signed [32:0] roll_r, pitch_r;

  assign num = cmd_i.phase ? -{rx_q[15], rx_q} : {ry_q[15], ry_q};
  assign sa  = cmd_i.phase ? ry_q : rx_q;
  assign w_eff = (weight_i > WEIGHT_ONE) ? {1'b0, WEIGHT_ONE} : {1'b0, weight_i};

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQA: begin mul_a = 18'(sa);   mul_b = 18'(sa);   end
      MUL_SQB: begin mul_a = 18'(rz_q); mul_b = 18'(rz_q); end
      MUL_FLO: begin mul_a = w_eff; mul_b = {1'b0, diff_q[16:0]}; end
      MUL_FHI: begin mul_a = w_eff; mul_b = {diff_q[33], diff_q[33:17]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // root step: pull two radicand bits, try the next root bit
  assign rem_sh = {rem_q[25:0], n_q[47:46]};
  assign trial  = {2'b00, root_q, 2'b01};

  // CORDIC result to Q7.8 with rounding and clamp
  always_comb begin
    ang_rnd = 18'((26'(ang_acc_q) + 26'sd128) >>> 8);
    if (num_zero_q) begin
      angle = '0;
    end else if (root_zero_q) begin
      angle = num_neg_q ? -16'(ANGLE_LIMIT) : 16'(ANGLE_LIMIT);
    end else if (ang_rnd > ANGLE_LIMIT) begin
      angle = 16'(ANGLE_LIMIT);
    end else if (ang_rnd < -ANGLE_LIMIT) begin
      angle = -16'(ANGLE_LIMIT);
    end else begin
      angle = 16'(ang_rnd);
    end
  end

  assign old_f     = cmd_i.phase ? pitch_f_q : roll_f_q;
  assign step_full = (acc_q + 52'sd32768) >>> 16;
  assign new_f     = old_f + 32'(step_full);

  assign roll_r  = 33'(roll_f_q) + 33'sd32768;
  assign pitch_r = 33'(pitch_f_q) + 33'sd32768;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load_in) begin
      rx_q <= in_data_i[15:0];
      ry_q <= in_data_i[31:16];
      rz_q <= in_data_i[47:32];
    end
    case (cmd_i.acc_op)
      ACC_LOAD:  acc_q <= 52'(prod_q);
      ACC_ADDHI: acc_q <= acc_q + (52'(prod_q) <<< 17);
      default:   acc_q <= acc_q;
    endcase
    if (cmd_i.root_init) begin
      n_q    <= {acc_q[31:0] + prod_q[31:0], 16'h0000};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      n_q <= {n_q[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[22:0], 1'b0};
      end
    end
    if (cmd_i.cord_init) begin
      u_q         <= {4'b0000, root_q};
      v_q         <= 28'(num) <<< 8;
      ang_acc_q   <= '0;
      num_zero_q  <= (num == '0);
      num_neg_q   <= num[16];
      root_zero_q <= (root_q == '0);
    end else if (cmd_i.cord_step) begin
      if (v_q > 0) begin
        u_q       <= u_q + (v_q >>> cmd_i.idx);
        v_q       <= v_q - (u_q >>> cmd_i.idx);
        ang_acc_q <= ang_acc_q + atan_tab(cmd_i.idx);
      end else begin
        u_q       <= u_q - (v_q >>> cmd_i.idx);
        v_q       <= v_q + (u_q >>> cmd_i.idx);
        ang_acc_q <= ang_acc_q - atan_tab(cmd_i.idx);
      end
    end
    if (cmd_i.ang_load) begin
      angle_q <= angle;
    end
    if (cmd_i.diff_load) begin
      diff_q <= (34'(angle_q) <<< 16) - 34'(old_f);
    end
    if (cmd_i.out_load) begin
      roll_out_q  <= -roll_r[31:16];
      pitch_out_q <= -pitch_r[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_f_q  <= '0;
      pitch_f_q <= '0;
    end else if (cmd_i.filt_upd) begin
      if (cmd_i.phase) begin
        pitch_f_q <= new_f;
      end else begin
        roll_f_q <= new_f;
      end
    end
  end

  assign out_data_o = {pitch_out_q, roll_out_q};

endmodule

// ===== design/accel_tilt_lowpass.sv =====
// Top level of the accelerometer tilt block: stream ports, APB weight
// register, sequencer and datapath. Depends on atl_pkg, atl_ctrl, atl_dpath.
//
// Takes one (x, y, z) accelerometer word and returns one word with the
// negated, low-pass filtered roll and pitch angles in signed Q7.8 degrees.
// Roll is atan2(y, sqrt(x^2+z^2)), pitch atan2(-x, sqrt(y^2+z^2)); each goes
// through new = old + w*(angle - old) with w from the filter_weight register
// (APB address 0, unsigned Q0.16, reset 0.06; values above 1.0 act as 1.0).
// The two angles run one after the other through one shared datapath: the
// squares and the root set-up, a bit-serial square root, the CORDIC set-up
// and 16 CORDIC iterations, and then rounding and filter arithmetic. A new
// word is not accepted while the previous one is in flight; the result
// goes to the output register once that register is empty or being read.
// The next word is accepted as soon as the result sits in the output
// register, even if the downstream side has not taken it yet.
module accel_tilt_lowpass (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // raw_x[15:0], raw_y[31:16], raw_z[47:32]
  // angle stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // roll_deg[15:0], pitch_deg[31:16]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atl_pkg::*;

  logic [16:0] weight_q;
  logic        reg_hit;
  atl_cmd_t    cmd;

  // Only register 0 exists; writes elsewhere are dropped.
  assign reg_hit = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {15'h0000, weight_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      weight_q <= pwdata[16:0];
    end
  end

  atl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  atl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .weight_i   (weight_q),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ===== design/atl_checker.sv =====
// Port-level checks for accel_tilt_lowpass, bound to the top level.
// Depends on accel_tilt_lowpass only through its ports.
module atl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // one word at a time: no back-to-back accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("sample accepted while previous word in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result word changed");

  a_weight_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2] |=>
      !(psel && !pwrite && !paddr[2]) || prdata[16:0] == $past(pwdata[16:0]))
    else $error("weight readback mismatch");

  a_weight_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite |-> prdata[31:17] == 15'h0000)
    else $error("weight readback upper bits set");

endmodule

bind accel_tilt_lowpass atl_checker u_atl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
